@@ rtl/core/plil_pkg.sv @@
// ----------------------------------------------------------------------------
// plil_pkg
// Shared types and constants for the piecewise-linear index lookup block:
// beat payloads, configuration bundle, controller/datapath interface.
// ----------------------------------------------------------------------------
package plil_pkg;

	// Default sizing handed to the top level parameters
	localparam int MAX_SEGMENTS_DEF        = 1024;
	localparam int SLOPE_FRAC_BITS_DEF     = 48;
	localparam int INTERCEPT_FRAC_BITS_DEF = 16;
	localparam int POSITION_BITS_DEF       = 32;

	// Fixed field widths
	localparam int KEY_W      = 64;
	localparam int COEF_W     = 64;
	localparam int SEG_IDX_W  = 10;
	localparam int POS_W      = 32;
	localparam int SEG_CNT_W  = 11;
	localparam int ERR_W      = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_CNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SEG_CNT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ERR_BOUND = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MERGED    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_NORMALIZE = 3'd6;

	// Request opcodes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	typedef struct packed {
		logic                     cmd;
		logic [SEG_IDX_W-1:0]     seg_index;
		logic [KEY_W-1:0]         key;
		logic signed [COEF_W-1:0] slope;
		logic signed [COEF_W-1:0] intercept;
	} req_t;

	typedef struct packed {
		logic [POS_W-1:0] lower_pos;
		logic [POS_W-1:0] upper_pos;
		logic             miss;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]     key_lower_bound;
		logic [KEY_W-1:0]     key_upper_bound;
		logic [POS_W-1:0]     entry_count;
		logic [SEG_CNT_W-1:0] segment_count;
		logic [ERR_W-1:0]     error_bound;
		logic                 merged_mode;
		logic                 normalize_mode;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic       seg_write;
		logic       key_load;
		logic       search_init;
		logic       search_step;
		logic       operand_load;
		logic       mul_en;
		logic [1:0] mul_k;
		logic       sum_en;
		logic       bound_en;
		logic       clamp_en;
		logic       out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic range_miss;
		logic search_done;
	} dp_status_t;

endpackage

@@ rtl/core/plil_ram.sv @@
// ----------------------------------------------------------------------------
// plil_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module plil_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/core/plil_ctrl.sv @@
// ----------------------------------------------------------------------------
// plil_ctrl
// Sequencer for one item at a time: range check, binary search steps,
// coefficient fetch, partial-product multiply, sum, bound and clamp, result beat.
// ----------------------------------------------------------------------------
module plil_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	input  logic                   req_is_lookup,
	output logic                   req_stall,
	input  logic                   rsp_stall,
	output logic                   rsp_valid,
	input  plil_pkg::dp_status_t   status,
	output plil_pkg::dp_cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_ISSUE,
		S_COMPARE,
		S_FETCH,
		S_LATCH,
		S_MUL,
		S_SUM,
		S_BOUND,
		S_CLAMP,
		S_DONE
	} state_t;

	// Four partial products, then a final drain for the accumulator
	localparam logic [2:0] MUL_LAST = 3'd4;

	state_t     state_q;
	logic [2:0] mul_cnt_q;
	logic       rsp_valid_q;
	logic       req_accept;
	logic       slot_free;

	assign req_stall  = (state_q != S_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign req_accept = req_valid && (state_q == S_IDLE);
	assign slot_free  = !rsp_valid_q || !rsp_stall;

	// Decode datapath commands from state
	always_comb begin
		cmd           = '0;
		cmd.seg_write = req_accept && !req_is_lookup;
		cmd.key_load  = req_accept && req_is_lookup;
		case (state_q)
			S_CHECK:   cmd.search_init  = 1'b1;
			S_COMPARE: cmd.search_step  = 1'b1;
			S_LATCH:   cmd.operand_load = 1'b1;
			S_MUL: begin
				cmd.mul_en = !mul_cnt_q[2];
				cmd.mul_k  = mul_cnt_q[1:0];
			end
			S_SUM:     cmd.sum_en   = 1'b1;
			S_BOUND:   cmd.bound_en = 1'b1;
			S_CLAMP:   cmd.clamp_en = 1'b1;
			S_DONE:    cmd.out_load = slot_free;
			default:   cmd.out_load = 1'b0;
		endcase
	end

	// State, multiply counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_accept && req_is_lookup) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					state_q <= status.range_miss ? S_DONE : S_ISSUE;
				end
				S_ISSUE: begin
					state_q <= status.search_done ? S_FETCH : S_COMPARE;
				end
				S_COMPARE: state_q <= S_ISSUE;
				S_FETCH:   state_q <= S_LATCH;
				S_LATCH: begin
					mul_cnt_q <= '0;
					state_q   <= S_MUL;
				end
				S_MUL: begin
					if (mul_cnt_q == MUL_LAST) begin
						mul_cnt_q <= '0;
						state_q   <= S_SUM;
					end else begin
						mul_cnt_q <= mul_cnt_q + 3'd1;
					end
				end
				S_SUM:   state_q <= S_BOUND;
				S_BOUND: state_q <= S_CLAMP;
				S_CLAMP: state_q <= S_DONE;
				S_DONE: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/plil_dp.sv @@
// ----------------------------------------------------------------------------
// plil_dp
// Datapath: segment tables, binary search bounds, 32x32 partial-product
// multiplier with accumulator, fixed-point sum, error window and clamping,
// and the result register.
// ----------------------------------------------------------------------------
module plil_dp #(
	parameter int MAX_SEGMENTS        = plil_pkg::MAX_SEGMENTS_DEF,
	parameter int SLOPE_FRAC_BITS     = plil_pkg::SLOPE_FRAC_BITS_DEF,
	parameter int INTERCEPT_FRAC_BITS = plil_pkg::INTERCEPT_FRAC_BITS_DEF,
	parameter int POSITION_BITS       = plil_pkg::POSITION_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  plil_pkg::cfg_t       cfg,
	input  plil_pkg::req_t       req,
	input  plil_pkg::dp_cmd_t    cmd,
	output plil_pkg::dp_status_t status,
	output plil_pkg::rsp_t       rsp
);

	localparam int AW         = $clog2(MAX_SEGMENTS);
	localparam int KW         = plil_pkg::KEY_W;
	localparam int CW         = plil_pkg::COEF_W;
	localparam int PW         = plil_pkg::POS_W;
	localparam int EW         = plil_pkg::ERR_W;
	localparam int TOTAL_FRAC = SLOPE_FRAC_BITS + INTERCEPT_FRAC_BITS;
	localparam int PROD_W     = 2 * KW;
	localparam int RES_W      = PROD_W + INTERCEPT_FRAC_BITS + 2;
	localparam int IP_W       = RES_W - TOTAL_FRAC;
	localparam int BND_W      = IP_W + 1;
	localparam logic [PW-1:0] POS_MASK = (POSITION_BITS >= PW) ? {PW{1'b1}} :
		PW'((64'd1 << POSITION_BITS) - 64'd1);

	// ------------------------------------------------------------------------
	// Derived configuration values
	// ------------------------------------------------------------------------
	logic [PW-1:0] count;
	logic [31:0]   seg_n;
	logic [31:0]   seg_last;
	logic          range_miss;

	assign count = cfg.entry_count & POS_MASK;

	// Clamp the segment count into the table
	always_comb begin
		seg_n = 32'(cfg.segment_count);
		if (seg_n < 32'd2) begin
			seg_n = 32'd2;
		end else if (seg_n > 32'(MAX_SEGMENTS)) begin
			seg_n = 32'(MAX_SEGMENTS);
		end
	end
	assign seg_last = seg_n - 32'd1;

	// ------------------------------------------------------------------------
	// Segment tables
	// ------------------------------------------------------------------------
	logic [31:0]     idx32;
	logic            idx_ok;
	logic [AW-1:0]   seg_addr;
	logic [AW-1:0]   left_q;
	logic [AW-1:0]   right_q;
	logic [AW-1:0]   mid;
	logic [AW:0]     mid_sum;
	logic [AW:0]     left_inc;
	logic [KW-1:0]   key_rdata;
	logic [2*CW-1:0] coef_rdata;

	assign idx32    = 32'(req.seg_index);
	assign idx_ok   = idx32 < 32'(MAX_SEGMENTS);
	assign seg_addr = idx32[AW-1:0];

	plil_ram #(
		.WIDTH (KW),
		.DEPTH (MAX_SEGMENTS)
	) u_key_ram (
		.clk   (clk),
		.we    (cmd.seg_write && idx_ok),
		.waddr (seg_addr),
		.wdata (req.key),
		.raddr (mid),
		.rdata (key_rdata)
	);

	plil_ram #(
		.WIDTH (2 * CW),
		.DEPTH (MAX_SEGMENTS)
	) u_coef_ram (
		.clk   (clk),
		.we    (cmd.seg_write && idx_ok),
		.waddr (seg_addr),
		.wdata ({req.slope, req.intercept}),
		.raddr (left_q),
		.rdata (coef_rdata)
	);

	// ------------------------------------------------------------------------
	// Key capture, range check and model input
	// ------------------------------------------------------------------------
	logic [KW-1:0] key_q;
	logic [KW-1:0] x_q;
	logic          range_miss_q;

	assign range_miss = (key_q > cfg.key_upper_bound) || (key_q < cfg.key_lower_bound) ||
		(count == '0);

	always_ff @(posedge clk) begin
		if (cmd.key_load) begin
			key_q <= req.key;
		end
		if (cmd.search_init) begin
			range_miss_q <= range_miss;
			x_q          <= cfg.normalize_mode ?
				(key_q - cfg.key_lower_bound + 64'd1) : key_q;
		end
	end

	// ------------------------------------------------------------------------
	// Binary search: narrow [left, right) one table read per step
	// ------------------------------------------------------------------------
	assign mid_sum  = {1'b0, left_q} + {1'b0, right_q};
	assign mid      = mid_sum[AW:1];
	assign left_inc = {1'b0, left_q} + {{AW{1'b0}}, 1'b1};

	assign status.range_miss  = range_miss;
	assign status.search_done = (left_inc == {1'b0, right_q});

	always_ff @(posedge clk) begin
		if (cmd.search_init) begin
			left_q  <= '0;
			right_q <= seg_last[AW-1:0];
		end else if (cmd.search_step) begin
			if (key_q < key_rdata) begin
				right_q <= mid;
			end else begin
				left_q <= mid;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Operands: slope magnitude and sign, intercept
	// ------------------------------------------------------------------------
	logic [CW-1:0]        slope_raw;
	logic [CW-1:0]        slope_mag_q;
	logic                 slope_neg_q;
	logic signed [CW-1:0] intercept_q;

	assign slope_raw = coef_rdata[2*CW-1:CW];

	always_ff @(posedge clk) begin
		if (cmd.operand_load) begin
			slope_neg_q <= slope_raw[CW-1];
			slope_mag_q <= slope_raw[CW-1] ? (CW'(0) - slope_raw) : slope_raw;
			intercept_q <= $signed(coef_rdata[CW-1:0]);
		end
	end

	// ------------------------------------------------------------------------
	// Multiply: four 32x32 partial products, registered, then accumulated
	// ------------------------------------------------------------------------
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [63:0]       pp_s1;
	logic [1:0]        pp_sh_s1;
	logic              pp_vld_s1;
	logic [PROD_W-1:0] pp_ext;
	logic [PROD_W-1:0] acc_q;

	assign mul_a = cmd.mul_k[0] ? x_q[63:32] : x_q[31:0];
	assign mul_b = cmd.mul_k[1] ? slope_mag_q[63:32] : slope_mag_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pp_vld_s1 <= 1'b0;
		end else begin
			pp_vld_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			pp_s1    <= 64'(mul_a) * 64'(mul_b);
			pp_sh_s1 <= {1'b0, cmd.mul_k[0]} + {1'b0, cmd.mul_k[1]};
		end
	end

	// Align the partial product by 0, 32 or 64 bits
	always_comb begin
		case (pp_sh_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd1:    pp_ext = {32'd0, pp_s1, 32'd0};
			2'd2:    pp_ext = {pp_s1, 64'd0};
			default: pp_ext = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.operand_load) begin
			acc_q <= '0;
		end else if (pp_vld_s1) begin
			acc_q <= acc_q + pp_ext;
		end
	end

	// ------------------------------------------------------------------------
	// Fixed-point sum: product and intercept aligned to TOTAL_FRAC bits
	// ------------------------------------------------------------------------
	logic signed [RES_W-1:0] prod_sh;
	logic signed [RES_W-1:0] icpt_sh;
	logic signed [RES_W-1:0] res_q;

	assign prod_sh = $signed({{(RES_W-PROD_W){1'b0}}, acc_q}) <<< INTERCEPT_FRAC_BITS;
	assign icpt_sh = $signed({{(RES_W-CW){intercept_q[CW-1]}}, intercept_q}) <<<
		SLOPE_FRAC_BITS;

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			res_q <= slope_neg_q ? (icpt_sh - prod_sh) : (icpt_sh + prod_sh);
		end
	end

	// ------------------------------------------------------------------------
	// Error window: floor minus bound, ceil plus bound
	// ------------------------------------------------------------------------
	logic signed [RES_W-1:0] res_sar;
	logic signed [BND_W-1:0] ip_ext;
	logic signed [BND_W-1:0] eb_ext;
	logic                    frac_nz;
	logic signed [BND_W-1:0] lower_w_q;
	logic signed [BND_W-1:0] upper_w_q;

	assign res_sar = res_q >>> TOTAL_FRAC;
	assign ip_ext  = $signed({res_sar[IP_W-1], res_sar[IP_W-1:0]});
	assign eb_ext  = $signed({{(BND_W-EW){1'b0}}, cfg.error_bound});
	assign frac_nz = |res_q[TOTAL_FRAC-1:0];

	always_ff @(posedge clk) begin
		if (cmd.bound_en) begin
			lower_w_q <= ip_ext - eb_ext;
			upper_w_q <= ip_ext + eb_ext + $signed({{(BND_W-1){1'b0}}, frac_nz});
		end
	end

	// ------------------------------------------------------------------------
	// Clamp upper to [0, count-1], lower at 0 from below; flag lower at or past count
	// ------------------------------------------------------------------------
	logic signed [BND_W-1:0] count_ext;
	logic [PW-1:0]           lower_q;
	logic [PW-1:0]           upper_q;
	logic                    lower_ge_q;

	assign count_ext = $signed({{(BND_W-PW){1'b0}}, count});

	always_ff @(posedge clk) begin
		if (cmd.clamp_en) begin
			if (upper_w_q[BND_W-1]) begin
				upper_q <= '0;
			end else if (upper_w_q >= count_ext) begin
				upper_q <= count - PW'(1);
			end else begin
				upper_q <= upper_w_q[PW-1:0];
			end

			if (lower_w_q[BND_W-1]) begin
				lower_q    <= '0;
				lower_ge_q <= 1'b0;
			end else begin
				lower_q    <= lower_w_q[PW-1:0];
				lower_ge_q <= (lower_w_q >= count_ext);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result: miss, merged repair or plain window
	// ------------------------------------------------------------------------
	logic [PW-1:0]  err_span;
	logic [PW-1:0]  lower_fix;
	plil_pkg::rsp_t rsp_d;
	plil_pkg::rsp_t rsp_q;

	assign err_span  = PW'({cfg.error_bound, 1'b1});
	assign lower_fix = (upper_q >= err_span) ? (upper_q - err_span) : '0;

	always_comb begin
		if (range_miss_q || (lower_ge_q && !cfg.merged_mode)) begin
			rsp_d.lower_pos = count;
			rsp_d.upper_pos = count;
			rsp_d.miss      = 1'b1;
		end else begin
			rsp_d.lower_pos = lower_ge_q ? lower_fix : lower_q;
			rsp_d.upper_pos = upper_q;
			rsp_d.miss      = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

@@ rtl/core/piecewise_linear_index_lookup.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_index_lookup
// Learned-index position predictor over a table of linear segments.
//
// Usage:
//   req channel (req_valid / req_stall / req): a load beat writes one segment
//   entry in the cycle it is accepted; a lookup beat yields one rsp beat.
//   rsp channel (rsp_valid / rsp_stall / rsp): lower/upper search positions
//   and a miss flag. cfg channel (cfg_valid / cfg_ready / cfg_index /
//   cfg_data) writes registers; write it only while no lookup is in flight.
//   One lookup is processed at a time. An out-of-range lookup goes from the
//   range check straight to the result beat. A hit runs S binary search
//   steps, where S is floor or ceil of log2(segment_count - 1), each a key
//   table read and compare, then the coefficient read, four 32x32 partial
//   products, the sum and the bound/clamp stages. A load does not stall
//   the input. req_stall is high from acceptance until the result is in the
//   output register; the next item is taken while that result waits on
//   rsp_stall. A stalled rsp beat holds. Reset puts the controller in idle
//   and the configuration registers at their defaults; segment tables are
//   not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
module piecewise_linear_index_lookup #(
	parameter int MAX_SEGMENTS        = plil_pkg::MAX_SEGMENTS_DEF,
	parameter int SLOPE_FRAC_BITS     = plil_pkg::SLOPE_FRAC_BITS_DEF,
	parameter int INTERCEPT_FRAC_BITS = plil_pkg::INTERCEPT_FRAC_BITS_DEF,
	parameter int POSITION_BITS       = plil_pkg::POSITION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  plil_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output plil_pkg::rsp_t                    rsp,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [plil_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [plil_pkg::CFG_DATA_W-1:0]   cfg_data
);

	plil_pkg::cfg_t       cfg_q;
	plil_pkg::dp_cmd_t    dp_cmd;
	plil_pkg::dp_status_t dp_status;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_lower_bound <= '0;
			cfg_q.key_upper_bound <= '1;
			cfg_q.entry_count     <= 32'd1;
			cfg_q.segment_count   <= 11'd2;
			cfg_q.error_bound     <= 16'd8;
			cfg_q.merged_mode     <= 1'b0;
			cfg_q.normalize_mode  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				plil_pkg::REG_KEY_LOWER: cfg_q.key_lower_bound <= cfg_data;
				plil_pkg::REG_KEY_UPPER: cfg_q.key_upper_bound <= cfg_data;
				plil_pkg::REG_ENTRY_CNT: cfg_q.entry_count     <= cfg_data[31:0];
				plil_pkg::REG_SEG_CNT:   cfg_q.segment_count   <= cfg_data[10:0];
				plil_pkg::REG_ERR_BOUND: cfg_q.error_bound     <= cfg_data[15:0];
				plil_pkg::REG_MERGED:    cfg_q.merged_mode     <= cfg_data[0];
				plil_pkg::REG_NORMALIZE: cfg_q.normalize_mode  <= cfg_data[0];
				default: cfg_q.merged_mode <= cfg_q.merged_mode;
			endcase
		end
	end

	plil_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_is_lookup (req.cmd == plil_pkg::CMD_LOOKUP),
		.req_stall     (req_stall),
		.rsp_stall     (rsp_stall),
		.rsp_valid     (rsp_valid),
		.status        (dp_status),
		.cmd           (dp_cmd)
	);

	plil_dp #(
		.MAX_SEGMENTS        (MAX_SEGMENTS),
		.SLOPE_FRAC_BITS     (SLOPE_FRAC_BITS),
		.INTERCEPT_FRAC_BITS (INTERCEPT_FRAC_BITS),
		.POSITION_BITS       (POSITION_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (req),
		.cmd    (dp_cmd),
		.status (dp_status),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	// A hit window never reaches past the last entry
	a_upper_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.miss |-> rsp.upper_pos < cfg_q.entry_count)
		else $error("hit upper position at or beyond entry count");

	// A hit window is ordered
	a_window_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.miss |-> rsp.lower_pos <= rsp.upper_pos)
		else $error("lower position above upper position");

	// A miss reports one position on both sides
	a_miss_equal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.miss |-> rsp.lower_pos == rsp.upper_pos)
		else $error("miss beat with differing positions");

	// A new result only comes out of a lookup in progress
	a_rsp_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("result beat raised while the block was idle");
`endif

endmodule
